### rtl/phpd_pkg.sv
package phpd_pkg;

    localparam int unsigned SAMPLE_BITS      = 10;
    localparam int unsigned TIME_BITS        = 32;
    localparam int unsigned DEBOUNCE_BITS    = 16;
    localparam int unsigned CFG_INDEX_BITS   = 1;
    localparam int unsigned CFG_DATA_BITS    = 16;

    localparam logic [SAMPLE_BITS-1:0]   HIT_DROP        = SAMPLE_BITS'(10);
    localparam logic [SAMPLE_BITS-1:0]   THRESHOLD_RESET = SAMPLE_BITS'(512);
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET  = DEBOUNCE_BITS'(50);

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIT_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_MS   = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   time_ms;
    } in_word_t;

    typedef struct packed {
        logic                   hit;
        logic                   release_res;
        logic                   event_res;
        logic                   in_hit;
        logic [SAMPLE_BITS-1:0] peak;
        logic [TIME_BITS-1:0]   event_interval_ms;
    } out_word_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   hit_threshold;
        logic [DEBOUNCE_BITS-1:0] debounce_ms;
    } cfg_t;

endpackage

### rtl/pad_hit_peak_detector_top.sv
// Pad hit peak detector. Each input word carries one ADC sample and its
// millisecond timestamp; each accepted word yields exactly one result word
// with the hit and release flags, the held hit level, the stored peak and
// the interval between the last two events. One word is taken every clock
// cycle while results drain. Each word waits in the input register, then
// the compare and update logic writes the state and the result register on
// the same edge, so the next word already sees the updated state. The
// result register is the only buffering on the output side; while it is
// full and not taken, a word held in the input register stays and in_ready
// drops. Configuration writes (index 0 hit_threshold, index 1
// debounce_ms) are always accepted and are meant for when no word is in
// flight; after reset the threshold is 512 and the debounce time 50 ms.
module pad_hit_peak_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  phpd_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output phpd_pkg::out_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [phpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [phpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import phpd_pkg::*;

    cfg_t      cfg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t result;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      advance;

    phpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // Advance the held word into the result register whenever there is room
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Load a new word only when the previous one moves on; hold it otherwise
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
    end

    phpd_detect u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_word_reg),
        .fire   (advance),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_word_reg))
        else $error("held input word lost during a stall");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word did not reach the result register");

    a_no_ready_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both registers are full");
`endif

endmodule

### rtl/phpd_cfg_regs.sv
module phpd_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [phpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [phpd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output phpd_pkg::cfg_t                        cfg
);
    import phpd_pkg::*;

    logic [SAMPLE_BITS-1:0]   hit_threshold_reg;
    logic [DEBOUNCE_BITS-1:0] debounce_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_threshold_reg <= THRESHOLD_RESET;
            debounce_ms_reg   <= DEBOUNCE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HIT_THRESHOLD: hit_threshold_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data[DEBOUNCE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg.hit_threshold = hit_threshold_reg;
    assign cfg.debounce_ms   = debounce_ms_reg;

endmodule

### rtl/phpd_detect.sv
module phpd_detect (
    input  logic                 clk,
    input  logic                 rst_n,
    input  phpd_pkg::cfg_t       cfg,
    input  phpd_pkg::in_word_t   item,
    input  logic                 fire,
    output phpd_pkg::out_word_t  result
);
    import phpd_pkg::*;

    logic                   hit_level_reg, hit_level_next;
    logic [SAMPLE_BITS-1:0] peak_value_reg, peak_value_next;
    logic [TIME_BITS-1:0]   last_event_time_reg, last_event_time_next;
    logic [TIME_BITS-1:0]   last_interval_reg, last_interval_next;

    logic [TIME_BITS-1:0]   elapsed;
    logic                   look;
    logic                   above;
    logic                   dropped;
    logic                   hit;
    logic                   rel;

    assign elapsed = item.time_ms - last_event_time_reg;
    assign look    = elapsed > {{(TIME_BITS-DEBOUNCE_BITS){1'b0}}, cfg.debounce_ms};
    assign above   = item.sample >= cfg.hit_threshold;
    // sample + drop < peak, one bit wider so the sum cannot wrap
    assign dropped = ({1'b0, item.sample} + {1'b0, HIT_DROP}) < {1'b0, peak_value_reg};

    always_comb
    begin
        hit             = 1'b0;
        rel             = 1'b0;
        hit_level_next  = hit_level_reg;
        peak_value_next = peak_value_reg;
        if (look)
        begin
            if (hit_level_reg)
            begin
                // peak is cleared on every word past the debounce window while a hit is held
                peak_value_next = '0;
                if (!above)
                begin
                    rel            = 1'b1;
                    hit_level_next = 1'b0;
                end
            end
            else if (above)
            begin
                if (item.sample > peak_value_reg)
                    peak_value_next = item.sample;
                else if (dropped && (peak_value_reg > cfg.hit_threshold))
                begin
                    hit            = 1'b1;
                    hit_level_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        last_event_time_next = last_event_time_reg;
        last_interval_next   = last_interval_reg;
        if (hit || rel)
        begin
            last_interval_next   = elapsed;
            last_event_time_next = item.time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_level_reg       <= 1'b0;
            peak_value_reg      <= '0;
            last_event_time_reg <= '0;
            last_interval_reg   <= '0;
        end
        else if (fire)
        begin
            hit_level_reg       <= hit_level_next;
            peak_value_reg      <= peak_value_next;
            last_event_time_reg <= last_event_time_next;
            last_interval_reg   <= last_interval_next;
        end
    end

    assign result.hit               = hit;
    assign result.release_res       = rel;
    assign result.event_res         = hit | rel;
    assign result.in_hit            = hit_level_next;
    assign result.peak              = peak_value_next;
    assign result.event_interval_ms = last_interval_next;

`ifndef NO_ASSERTIONS
    a_hit_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit |=> hit_level_reg && (peak_value_reg == $past(peak_value_reg)))
        else $error("hit did not latch the hit level");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rel |=> !hit_level_reg && (peak_value_reg == '0))
        else $error("release did not clear level and peak");

    a_event_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (hit || rel) |=> last_event_time_reg == $past(item.time_ms))
        else $error("event time not recorded");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(hit_level_reg) && $stable(peak_value_reg)
                  && $stable(last_event_time_reg) && $stable(last_interval_reg))
        else $error("state moved without an item");
`endif

endmodule

### dv/pad_hit_peak_detector_top_tb.sv
`timescale 1ns / 100ps

module pad_hit_peak_detector_top_tb;

    import phpd_pkg::*;

    typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

    // One row of the directed table: either a sample word or a register write.
    // Where typed is set the expected result is written out in full; otherwise
    // the predictor supplies it.
    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  cdata;
        in_word_t                  word;
        bit                        typed;
        out_word_t                 want;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_word_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    out_word_t                 out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Shadow of the block: configuration and detector state
    logic [SAMPLE_BITS-1:0]   thr_cfg;
    logic [DEBOUNCE_BITS-1:0] debounce_cfg;
    bit                       in_stroke;
    logic [SAMPLE_BITS-1:0]   held_peak;
    logic [TIME_BITS-1:0]     last_event_ms;
    logic [TIME_BITS-1:0]     gap_ms;

    out_word_t            pending_q[$];
    int                   errors;
    int                   phase_words;
    logic [TIME_BITS-1:0] clock_ms;

    // Traffic shaping flags for the stimulus (feed_lazy, burst) and the receiver (drain_lazy, hold_req)
    bit feed_lazy;
    bit drain_lazy;
    bit burst;
    bit hold_req;

    // Directed sequence: debounce edges after reset, a full hit and release at
    // the reset threshold, a peak that sits at the threshold, a peak too small
    // to trigger, an over-wide threshold write and the widest debounce window.
    dir_row_t dir_tab [25] = '{
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd600, 32'd10}, 1, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd600, 32'd50}, 1, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd1023, 32'd51}, 1,
          '{0,0,0,0,10'd1023,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd400, 32'd60}, 1,
          '{0,0,0,0,10'd1023,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd1013, 32'd70}, 1,
          '{0,0,0,0,10'd1023,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd1012, 32'd80}, 1,
          '{1,0,1,1,10'd1023,32'd80}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd0, 32'd100}, 1,
          '{0,0,0,1,10'd1023,32'd80}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd700, 32'd131}, 1,
          '{0,0,0,1,10'd0,32'd80}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd0, 32'd200}, 1, '{0,1,1,0,10'd0,32'd120}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd511, 32'd300}, 1, '{0,0,0,0,10'd0,32'd120}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd600, 32'd310}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd589, 32'd330}, 1,
          '{1,0,1,1,10'd600,32'd130}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd100, 32'd400}, 1, '{0,1,1,0,10'd0,32'd70}},
        '{ROW_CFG, REG_HIT_THRESHOLD, 16'hFC03, '{10'd0, 32'd0}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_CFG, REG_DEBOUNCE_MS, 16'h0000, '{10'd0, 32'd0}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd10, 32'd401}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd3, 32'd402}, 1, '{0,0,0,0,10'd10,32'd70}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd14, 32'd403}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd3, 32'd404}, 1, '{1,0,1,1,10'd14,32'd4}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd2, 32'd404}, 1, '{0,0,0,1,10'd14,32'd4}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd2, 32'd405}, 1, '{0,1,1,0,10'd0,32'd1}},
        '{ROW_CFG, REG_HIT_THRESHOLD, 16'hFFFF, '{10'd0, 32'd0}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_CFG, REG_DEBOUNCE_MS, 16'hFFFF, '{10'd0, 32'd0}, 0, '{0,0,0,0,10'd0,32'd0}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd1023, 32'd65940}, 1,
          '{0,0,0,0,10'd0,32'd1}},
        '{ROW_WORD, REG_HIT_THRESHOLD, 16'h0, '{10'd1023, 32'd65941}, 1,
          '{0,0,0,0,10'd1023,32'd1}}
    };

    pad_hit_peak_detector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Advance the shadow detector by one accepted sample word and return the
    // result word it must produce.
    function automatic out_word_t predict_pad(input in_word_t w);
        out_word_t            r;
        bit                   above;
        logic [TIME_BITS-1:0] since;
        since   = w.time_ms - last_event_ms;
        r.hit         = 1'b0;
        r.release_res = 1'b0;
        // Inside the debounce window nothing moves, not even the peak
        if (since > TIME_BITS'(debounce_cfg))
        begin
            above = (w.sample >= thr_cfg);
            if (in_stroke)
                held_peak = '0;
            if (above != in_stroke)
            begin
                if (above && w.sample > held_peak)
                    held_peak = w.sample;
                else if ((11'(w.sample) + 11'(HIT_DROP)) < 11'(held_peak) &&
                         held_peak > thr_cfg)
                begin
                    r.hit         = 1'b1;
                    in_stroke     = 1'b1;
                    gap_ms        = w.time_ms - last_event_ms;
                    last_event_ms = w.time_ms;
                end
                else if (!above)
                begin
                    r.release_res = 1'b1;
                    held_peak     = '0;
                    in_stroke     = 1'b0;
                    gap_ms        = w.time_ms - last_event_ms;
                    last_event_ms = w.time_ms;
                end
            end
        end
        r.event_res         = r.hit | r.release_res;
        r.in_hit            = in_stroke;
        r.peak              = held_peak;
        r.event_interval_ms = gap_ms;
        return r;
    endfunction

    // Offer one word, entered and left at a falling edge. Valid is only
    // dropped when an idle gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        int        gap;
        out_word_t guess;
        gap = (feed_lazy && !burst) ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        guess = predict_pad(w);
        pending_q.push_back(typed ? want : guess);
        phase_words++;
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding result drain, then allow for the
    // two-stage pipe so nothing is left in flight before a register write.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_HIT_THRESHOLD)
            thr_cfg = val[SAMPLE_BITS-1:0];
        else
            debounce_cfg = val[DEBOUNCE_BITS-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly step past the debounce window, sometimes land inside it, and
    // now and then jump anywhere so that the timestamp wraps.
    function automatic logic [TIME_BITS-1:0] next_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            clock_ms = clock_ms + TIME_BITS'(debounce_cfg) + 1 + $urandom_range(0, 30);
        else if (pick < 92)
            clock_ms = clock_ms + $urandom_range(0, debounce_cfg);
        else
            clock_ms = $urandom();
        return clock_ms;
    endfunction

    task automatic feed(input int unsigned lvl);
        in_word_t w;
        w.sample  = SAMPLE_BITS'(lvl);
        w.time_ms = next_time();
        send_word(w, 1'b0, '0);
    endtask

    // One well-formed pad strike: climb to a peak, fall back far enough to
    // fire, linger above the threshold, then drop below it for the release.
    task automatic play_stroke();
        int unsigned thr;
        int unsigned top;
        int          climb;
        thr   = 32'(thr_cfg);
        top   = (thr <= 1012) ? $urandom_range(thr + 11, 1023) : $urandom_range(thr, 1023);
        climb = $urandom_range(1, 4);
        for (int i = 0; i < climb; i++)
            feed((i == climb - 1) ? top : $urandom_range(thr, top));
        if (top >= thr + 11)
            feed($urandom_range(thr, top - 11));
        repeat ($urandom_range(0, 2)) feed($urandom_range(thr, 1023));
        if (thr > 0)
            feed($urandom_range(0, thr - 1));
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
            errors++;
        end
    endtask

    // Compare every result word taken from the block against the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected, got %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                check_field("hit", 32'(want.hit), 32'(out_data.hit));
                check_field("release_res", 32'(want.release_res), 32'(out_data.release_res));
                check_field("event_res", 32'(want.event_res), 32'(out_data.event_res));
                check_field("in_hit", 32'(want.in_hit), 32'(out_data.in_hit));
                check_field("peak", 32'(want.peak), 32'(out_data.peak));
                check_field("event_interval_ms", want.event_interval_ms,
                            out_data.event_interval_ms);
            end
        end
    end

    // Receiver: draw a wait before each word, hold ready high when the wait
    // is zero, and serve a long hold-off on request so the pipe backs up.
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            else
            begin
                gap = drain_lazy ? $urandom_range(0, 7) : 0;
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            if (taken % 64 == 0)
                drain_lazy = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [SAMPLE_BITS-1:0]   phase_thr [6];
        logic [DEBOUNCE_BITS-1:0] phase_deb [6];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_HIT_THRESHOLD;
        cfg_data   = '0;
        errors     = 0;
        feed_lazy  = 1'b1;
        drain_lazy = 1'b1;
        burst      = 1'b0;
        hold_req   = 1'b0;
        clock_ms   = '0;

        // Hold the shadow in its reset state alongside the block
        thr_cfg       = THRESHOLD_RESET;
        debounce_cfg  = DEBOUNCE_RESET;
        in_stroke     = 1'b0;
        held_peak     = '0;
        last_event_ms = '0;
        gap_ms        = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(dir_tab[i].idx, dir_tab[i].cdata);
            end
            else
                send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases: reset values under pressure, the two extremes, a
        // sensitive and a stiff setting, then a random one.
        phase_thr = '{10'd512, 10'd0, 10'd1023, 10'd100, 10'd900, 10'd0};
        phase_deb = '{16'd50, 16'd0, 16'hFFFF, 16'd5, 16'd20, 16'd0};
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            if (ph == 5)
            begin
                write_reg(REG_HIT_THRESHOLD, CFG_DATA_BITS'($urandom_range(0, 65535)));
                write_reg(REG_DEBOUNCE_MS, CFG_DATA_BITS'($urandom_range(0, 300)));
            end
            else
            begin
                write_reg(REG_HIT_THRESHOLD, CFG_DATA_BITS'(phase_thr[ph]));
                write_reg(REG_DEBOUNCE_MS, phase_deb[ph]);
            end
            // Start the widest-debounce phase just short of the wrap
            clock_ms    = (ph == 2) ? 32'hFFFF_FF00 : $urandom();
            phase_words = 0;
            if (ph == 0)
            begin
                burst    = 1'b1;
                hold_req = 1'b1;
            end
            while (phase_words < 135)
            begin
                if (phase_words >= 40)
                    burst = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4)) feed($urandom_range(0, 1023));
                else
                    play_stroke();
                if ($urandom_range(0, 7) == 0)
                    feed_lazy = !feed_lazy;
            end
        end

        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/phpd_pkg.sv
rtl/phpd_cfg_regs.sv
rtl/phpd_detect.sv
rtl/pad_hit_peak_detector_top.sv
dv/pad_hit_peak_detector_top_tb.sv
